// File: rtl/lse_pkg.sv
package lse_pkg;

  // Field and register widths.
  localparam int CNT_W     = 3;
  localparam int COEF_W    = 24;
  localparam int X_W       = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 24;
  localparam int VAL_W     = 28;

  // Internal datapath widths.
  localparam int P_W    = 18;
  localparam int PROD_W = X_W + P_W;
  localparam int FRAC_W = 14;
  localparam int T_W    = PROD_W - FRAC_W;
  localparam int NUM_W  = 25;
  localparam int MAG_W  = 24;
  localparam int RCP_W  = 25;
  localparam int RCP_SH = 25;
  localparam int CPR_W  = COEF_W + P_W;
  localparam int TERM_W = CPR_W - FRAC_W;
  localparam int ACC_W  = 32;

  // Fixed-point one in Q2.14.
  localparam int ONE_Q14 = 16384;

  // Default number of supported terms.
  localparam int DEF_MAX_TERMS = 7;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_0     = 4'd1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEED_X,
    ST_MUL_X,
    ST_NUM,
    ST_RECIP,
    ST_FIX,
    ST_DRAIN_A,
    ST_DRAIN_B,
    ST_FINISH
  } lse_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             seed_one;
    logic             seed_x;
    logic             mul_x;
    logic             num;
    logic             recip;
    logic             fix;
    logic             finish;
    logic [CNT_W-1:0] idx;
  } lse_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             x_oor;
    logic [CNT_W-1:0] n_terms;
  } lse_status_t;

  // Reciprocal floor(2^25 / i) for the exact division by the term index.
  function automatic logic [RCP_W-1:0] recip_of(input logic [CNT_W-1:0] i);
    logic [RCP_W-1:0] r;
    unique case (i)
      3'd2:    r = 25'd16777216;
      3'd3:    r = 25'd11184810;
      3'd4:    r = 25'd8388608;
      3'd5:    r = 25'd6710886;
      3'd6:    r = 25'd5592405;
      3'd7:    r = 25'd4793490;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/lse_ctrl.sv
module lse_ctrl #(
  parameter int MAX_TERMS = lse_pkg::DEF_MAX_TERMS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  lse_pkg::lse_status_t status_i,
  output lse_pkg::lse_cmd_t   cmd_o,
  output logic                busy_o
);
  import lse_pkg::*;

  lse_state_e       state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;

  // State and term index registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.idx = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.x_oor || (status_i.n_terms == '0)) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.seed_one = 1'b1;
          if (status_i.n_terms == CNT_W'(1)) begin
            state_d = ST_DRAIN_A;
          end else begin
            idx_d   = CNT_W'(1);
            state_d = ST_SEED_X;
          end
        end
      end
      ST_SEED_X: begin
        cmd_o.seed_x = 1'b1;
        if (status_i.n_terms == CNT_W'(2)) begin
          state_d = ST_DRAIN_A;
        end else begin
          idx_d   = CNT_W'(2);
          state_d = ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        cmd_o.mul_x = 1'b1;
        state_d     = ST_NUM;
      end
      ST_NUM: begin
        cmd_o.num = 1'b1;
        state_d   = ST_RECIP;
      end
      ST_RECIP: begin
        cmd_o.recip = 1'b1;
        state_d     = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        if (idx_q == (status_i.n_terms - CNT_W'(1))) begin
          state_d = ST_DRAIN_A;
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = ST_MUL_X;
        end
      end
      ST_DRAIN_A: state_d = ST_DRAIN_B;
      ST_DRAIN_B: state_d = ST_FINISH;
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  // A started transaction always leaves the idle state.
  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) && start_i |=> (state_q == ST_CHECK))
    else $error("start did not begin a transaction");

  // The recurrence never runs past the clamped term count.
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fix |-> (idx_q < status_i.n_terms) && (idx_q < CNT_W'(MAX_TERMS)))
    else $error("term index beyond term count");

endmodule

// File: rtl/lse_datapath.sv
module lse_datapath #(
  parameter int MAX_TERMS = lse_pkg::DEF_MAX_TERMS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [lse_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [lse_pkg::CFG_W-1:0]              cfg_data_i,
  input  logic signed [lse_pkg::X_W-1:0]         cos_theta_i,
  input  lse_pkg::lse_cmd_t                      cmd_i,
  output lse_pkg::lse_status_t                   status_o,
  output logic signed [lse_pkg::VAL_W-1:0]       series_value_o,
  output logic                                   beyond_one_o,
  output logic                                   done_o
);
  import lse_pkg::*;

  localparam int IdxW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  // Configuration registers.
  logic [CNT_W-1:0]         term_count_q;
  logic signed [COEF_W-1:0] coef_q [MAX_TERMS];

  // Recurrence registers.
  logic signed [X_W-1:0]    x_q;
  logic signed [P_W-1:0]    pm1_q, pm2_q, p_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     neg_q;
  logic [MAG_W-1:0]         mag_q, qe_q;

  // Weighting and accumulation registers.
  logic                     pv_q, prv_q;
  logic [IdxW-1:0]          pidx_q;
  logic signed [CPR_W-1:0]  cprod_q;
  logic signed [ACC_W-1:0]  acc_q;

  // Result registers.
  logic                     done_q, oor_q;
  logic signed [VAL_W-1:0]  val_q;

  // Combinational helpers.
  logic                     x_oor;
  logic signed [T_W-1:0]    t_w;
  logic [3:0]               a_w;
  logic [CNT_W-1:0]         b_w;
  logic signed [NUM_W-1:0]  num_w;
  logic [MAG_W+RCP_W-1:0]   rprod_w;
  logic [MAG_W+CNT_W-1:0]   qi_w;
  logic [MAG_W-1:0]         rem_w, rem_fix_w, q_w;
  logic                     rem_ge_w;
  logic signed [P_W-1:0]    p_fix_w;
  logic signed [ACC_W-1:0]  sum_next_w;
  logic signed [VAL_W-1:0]  sat_w;

  // Configuration writes; indexes beyond the register list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= '0;
      for (int k = 0; k < MAX_TERMS; k++) begin
        coef_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_TERM_COUNT) begin
        term_count_q <= cfg_data_i[CNT_W-1:0];
      end
      for (int k = 0; k < MAX_TERMS; k++) begin
        if (cfg_index_i == (REG_COEF_0 + CFG_IDX_W'(k))) begin
          coef_q[k] <= $signed(cfg_data_i[COEF_W-1:0]);
        end
      end
    end
  end

  // Range check and clamped term count for the controller.
  assign x_oor = (x_q > X_W'(ONE_Q14)) || (x_q < -X_W'(ONE_Q14));
  assign status_o.x_oor   = x_oor;
  assign status_o.n_terms = (term_count_q > CNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
                                                               : term_count_q;

  // Numerator (2i-1)*t - (i-1)*P(i-2).
  assign t_w   = prod_q[PROD_W-1:FRAC_W];
  assign a_w   = {cmd_i.idx, 1'b0} - 4'd1;
  assign b_w   = cmd_i.idx - CNT_W'(1);
  assign num_w = NUM_W'(t_w) * NUM_W'($signed({1'b0, a_w}))
               - NUM_W'(pm2_q) * NUM_W'($signed({1'b0, b_w}));

  // Quotient estimate by reciprocal, then one correction step.
  assign rprod_w   = MAG_W'(mag_q) * recip_of(cmd_i.idx);
  assign qi_w      = qe_q * cmd_i.idx;
  assign rem_w     = mag_q - qi_w[MAG_W-1:0];
  assign rem_ge_w  = (rem_w >= MAG_W'(cmd_i.idx));
  assign rem_fix_w = rem_ge_w ? (rem_w - MAG_W'(cmd_i.idx)) : rem_w;
  assign q_w       = qe_q + MAG_W'(rem_ge_w);
  assign p_fix_w   = neg_q ? -$signed(q_w[P_W-1:0]) : $signed(q_w[P_W-1:0]);

  // Accumulate the shifted weighted term, sign-extended to the accumulator.
  assign sum_next_w = acc_q + ACC_W'($signed(cprod_q[CPR_W-1:FRAC_W]));

  // Saturate the exact sum to the result width.
  always_comb begin
    if (acc_q[ACC_W-1:VAL_W-1] == '0 || acc_q[ACC_W-1:VAL_W-1] == '1) begin
      sat_w = acc_q[VAL_W-1:0];
    end else if (acc_q[ACC_W-1]) begin
      sat_w = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_w = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  // Control flags of the term pipeline and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      prv_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      pv_q   <= cmd_i.seed_one || cmd_i.seed_x || cmd_i.fix;
      prv_q  <= pv_q;
      done_q <= cmd_i.finish;
    end
  end

  // Recurrence, weighting and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= cos_theta_i;
      pm2_q <= P_W'(ONE_Q14);
      pm1_q <= P_W'(cos_theta_i);
      acc_q <= '0;
    end else if (prv_q) begin
      acc_q <= sum_next_w;
    end
    if (cmd_i.mul_x) begin
      prod_q <= PROD_W'(x_q) * PROD_W'(pm1_q);
    end
    if (cmd_i.num) begin
      neg_q <= num_w[NUM_W-1];
      mag_q <= num_w[NUM_W-1] ? MAG_W'(-num_w) : MAG_W'(num_w);
    end
    if (cmd_i.recip) begin
      qe_q <= rprod_w[RCP_SH +: MAG_W];
    end
    if (cmd_i.seed_one) begin
      p_q <= P_W'(ONE_Q14);
    end else if (cmd_i.seed_x) begin
      p_q <= P_W'(x_q);
    end else if (cmd_i.fix) begin
      p_q   <= p_fix_w;
      pm2_q <= pm1_q;
      pm1_q <= p_fix_w;
    end
    if (cmd_i.seed_one || cmd_i.seed_x || cmd_i.fix) begin
      pidx_q <= cmd_i.idx[IdxW-1:0];
    end
    if (pv_q) begin
      cprod_q <= CPR_W'(coef_q[pidx_q]) * CPR_W'(p_q);
    end
    if (cmd_i.finish) begin
      oor_q <= x_oor;
      val_q <= x_oor ? '0 : sat_w;
    end
  end

  assign series_value_o = val_q;
  assign beyond_one_o   = oor_q;
  assign done_o         = done_q;

  // An argument beyond one always reports a zero value.
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && oor_q |-> (val_q == '0))
    else $error("out of range result with nonzero value");

  // The corrected remainder of the division stays below the divisor.
  a_div_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fix |-> (rem_fix_w < MAG_W'(cmd_i.idx)))
    else $error("division by term index needs more than one correction");

endmodule

// File: rtl/legendre_series_evaluator_unit.sv
// Legendre series evaluator.
// Computes sum of coef_i * P_i(x) for i below term_count, with x = cos_theta_i in
// signed Q2.14 and the result in signed Q12.16, saturated to 28 bits.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i at the clock
// edge (0 = term_count, 1..7 = coef_0..coef_6); other indexes are ignored. Write
// only while busy_o is low and no result is pending.
// Input: a transaction is taken at a clock edge with start_i high and busy_o low.
// Output: done_o is high for exactly one cycle with series_value_o and
// beyond_one_o; the receiver cannot stall, so the result must be taken then.
// Sequence: busy_o stays high through the check and finish states when the
// argument is beyond one or the clamped term count n is zero; otherwise also
// through two drain states, a seed state for n >= 2 and one recurrence step per
// term from the third on. Each step runs through its multiply, numerator,
// reciprocal multiply and correction registers in turn. The result strobe
// appears in the first cycle with busy_o low, and start_i is taken in that cycle.
// Reset clears the sequencer, the result strobe and all configuration registers.
module legendre_series_evaluator_unit #(
  parameter int MAX_TERMS = lse_pkg::DEF_MAX_TERMS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lse_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lse_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [lse_pkg::X_W-1:0]   cos_theta_i,
  output logic                             done_o,
  output logic signed [lse_pkg::VAL_W-1:0] series_value_o,
  output logic                             beyond_one_o
);
  import lse_pkg::*;

  lse_cmd_t    cmd;
  lse_status_t status;

  // Sequencer.
  lse_ctrl #(
    .MAX_TERMS(MAX_TERMS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .status_i(status),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Arithmetic and configuration storage.
  lse_datapath #(
    .MAX_TERMS(MAX_TERMS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cos_theta_i   (cos_theta_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .series_value_o(series_value_o),
    .beyond_one_o  (beyond_one_o),
    .done_o        (done_o)
  );

  // A result is only shown once the sequencer has returned to idle.
  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // Each transaction yields one strobe; two never follow each other directly.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule
